>>> design/rc4xd_pkg.sv
// Shared types and constants for the RC4 keyed XOR stream decoder.
`timescale 1ns / 1ps

package rc4xd_pkg;

   localparam int BoxSize = 256;

   localparam logic [1:0] MODE_KEY   = 2'd0;
   localparam logic [1:0] MODE_AUDIO = 2'd1;
   localparam logic [1:0] MODE_SEEK  = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_KEY_READY = 2'd1;
   localparam logic [1:0] STATUS_PAST_END  = 2'd2;
   localparam logic [1:0] STATUS_ERROR     = 2'd3;

   // controller -> datapath
   typedef struct packed {
      logic accept;
      logic fill;
      logic ks_j;
      logic ks_rd_j;
      logic ks_sw1;
      logic ks_sw2;
      logic tb_rd_k;
      logic tb_rd_b;
      logic tb_rd_c;
      logic tb_wr;
      logic emit_ready;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic slot_free;
      logic build_go;
      logic idx_last;
   } sts_type;

endpackage

>>> design/rc4xd_ctrl.sv
// Sequencer for item intake, key schedule and table build.
`timescale 1ns / 1ps

module rc4xd_ctrl
   import rc4xd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [11:0] {
      ST_IDLE    = 12'b0000_0000_0001,
      ST_FILL    = 12'b0000_0000_0010,
      ST_KS_RD_I = 12'b0000_0000_0100,
      ST_KS_J    = 12'b0000_0000_1000,
      ST_KS_RD_J = 12'b0000_0001_0000,
      ST_KS_SW1  = 12'b0000_0010_0000,
      ST_KS_SW2  = 12'b0000_0100_0000,
      ST_TB_RD_K = 12'b0000_1000_0000,
      ST_TB_RD_B = 12'b0001_0000_0000,
      ST_TB_RD_C = 12'b0010_0000_0000,
      ST_TB_WR   = 12'b0100_0000_0000,
      ST_DONE    = 12'b1000_0000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_stall = !((state_ff == ST_IDLE) && sts.slot_free);

   always_comb begin
      cmd            = '0;
      cmd.accept     = req_valid && !req_stall;
      cmd.fill       = (state_ff == ST_FILL);
      cmd.ks_j       = (state_ff == ST_KS_J);
      cmd.ks_rd_j    = (state_ff == ST_KS_RD_J);
      cmd.ks_sw1     = (state_ff == ST_KS_SW1);
      cmd.ks_sw2     = (state_ff == ST_KS_SW2);
      cmd.tb_rd_k    = (state_ff == ST_TB_RD_K);
      cmd.tb_rd_b    = (state_ff == ST_TB_RD_B);
      cmd.tb_rd_c    = (state_ff == ST_TB_RD_C);
      cmd.tb_wr      = (state_ff == ST_TB_WR);
      cmd.emit_ready = (state_ff == ST_DONE) && sts.slot_free;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.accept && sts.build_go) state_in = ST_FILL;
         end
         ST_FILL: begin
            if (sts.idx_last) state_in = ST_KS_RD_I;
         end
         ST_KS_RD_I: state_in = ST_KS_J;
         ST_KS_J:    state_in = ST_KS_RD_J;
         ST_KS_RD_J: state_in = ST_KS_SW1;
         ST_KS_SW1:  state_in = ST_KS_SW2;
         ST_KS_SW2: begin
            state_in = sts.idx_last ? ST_TB_RD_K : ST_KS_RD_I;
         end
         ST_TB_RD_K: state_in = ST_TB_RD_B;
         ST_TB_RD_B: state_in = ST_TB_RD_C;
         ST_TB_RD_C: state_in = ST_TB_WR;
         ST_TB_WR: begin
            state_in = sts.idx_last ? ST_DONE : ST_TB_RD_K;
         end
         ST_DONE: begin
            if (sts.slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_build_starts: assert property (@(posedge clock) disable iff (reset)
      cmd.accept && sts.build_go |=> state_ff == ST_FILL)
      else $error("key build did not start");
   a_table_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TB_WR && sts.idx_last |=> state_ff == ST_DONE)
      else $error("table build did not finish");
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register not one-hot");
`endif

endmodule

>>> design/rc4xd_datapath.sv
// Key store, permutation box, stream table, position and result register.
`timescale 1ns / 1ps

module rc4xd_datapath
   import rc4xd_pkg::*;
#(
   parameter int MAX_KEY_BYTES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_in,
   input  logic [47:0] req_seek_position,
   input  logic        csr_wr_en,
   input  logic [47:0] csr_wr_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_data_out,
   output logic [1:0]  rsp_status,
   output logic        rsp_last_out
);

   localparam int KCW = $clog2(MAX_KEY_BYTES + 1);
   localparam int KAW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
   localparam logic [KCW-1:0] KEY_MAX = KCW'(MAX_KEY_BYTES);

   logic [7:0]     key_mem [MAX_KEY_BYTES];
   logic [7:0]     key_rd_ff;
   logic [7:0]     perm_mem [BoxSize];
   logic [7:0]     perm_rd_ff;
   logic [7:0]     tbl_mem [BoxSize];
   logic [7:0]     tbl_rd_ff;

   logic [KCW-1:0] key_count_ff, key_count_in;
   logic           key_over_ff, key_over_in;
   logic [KCW-1:0] klen_ff, klen_in;
   logic [KAW-1:0] kidx_ff, kidx_in;
   logic [7:0]     idx_ff, idx_in;
   logic [7:0]     j_ff, j_in;
   logic [7:0]     si_ff, si_in;
   logic [47:0]    pos_ff, pos_in;
   logic [47:0]    len_ff, len_in;
   logic           key_ready_ff, key_ready_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     rsp_data_ff, rsp_data_in;
   logic [1:0]     rsp_status_ff, rsp_status_in;
   logic           rsp_last_ff, rsp_last_in;
   logic           rsp_load;

   logic           key_we;
   logic           perm_we;
   logic [7:0]     perm_waddr, perm_wdata, perm_raddr;
   logic           over_now;
   logic [7:0]     k_addr;

   assign over_now      = key_over_ff || (key_count_ff == KEY_MAX);
   assign k_addr        = 8'(idx_ff + 8'd1);
   assign sts.slot_free = !rsp_valid_ff || !rsp_stall;
   assign sts.idx_last  = (idx_ff == 8'hFF);
   assign sts.build_go  = (req_mode == MODE_KEY) && req_last_in && !over_now;

   always_comb begin
      perm_raddr = idx_ff;
      if (cmd.ks_rd_j) perm_raddr = j_ff;
      if (cmd.tb_rd_k) perm_raddr = k_addr;
      if (cmd.tb_rd_b) perm_raddr = 8'(k_addr + perm_rd_ff);
      if (cmd.tb_rd_c) perm_raddr = 8'(si_ff + perm_rd_ff);

      perm_we    = cmd.fill || cmd.ks_sw1 || cmd.ks_sw2;
      perm_waddr = cmd.ks_sw2 ? j_ff : idx_ff;
      perm_wdata = idx_ff;
      if (cmd.ks_sw1) perm_wdata = perm_rd_ff;
      if (cmd.ks_sw2) perm_wdata = si_ff;
   end

   always_comb begin
      key_count_in  = key_count_ff;
      key_over_in   = key_over_ff;
      klen_in       = klen_ff;
      kidx_in       = kidx_ff;
      idx_in        = idx_ff;
      j_in          = j_ff;
      si_in         = si_ff;
      pos_in        = pos_ff;
      len_in        = csr_wr_en ? csr_wr_data : len_ff;
      key_ready_in  = key_ready_ff;
      key_we        = 1'b0;
      rsp_load      = 1'b0;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;

      if (cmd.accept) begin
         case (req_mode)
            MODE_KEY: begin
               key_ready_in = 1'b0;
               if (key_count_ff < KEY_MAX) begin
                  key_we       = 1'b1;
                  key_count_in = KCW'(key_count_ff + KCW'(1));
               end else begin
                  key_over_in = 1'b1;
               end
               if (req_last_in) begin
                  key_count_in = '0;
                  key_over_in  = 1'b0;
                  if (over_now) begin
                     rsp_load      = 1'b1;
                     rsp_data_in   = 8'd0;
                     rsp_status_in = STATUS_ERROR;
                     rsp_last_in   = req_last_in;
                  end else begin
                     klen_in = KCW'(key_count_ff + KCW'(1));
                     kidx_in = '0;
                     idx_in  = 8'd0;
                     j_in    = 8'd0;
                  end
               end
            end
            MODE_AUDIO: begin
               rsp_load    = 1'b1;
               rsp_last_in = req_last_in;
               rsp_data_in = 8'd0;
               if (!key_ready_ff) begin
                  rsp_status_in = STATUS_ERROR;
               end else if (pos_ff >= len_ff) begin
                  rsp_status_in = STATUS_PAST_END;
               end else begin
                  rsp_status_in = STATUS_OK;
                  rsp_data_in   = req_data_byte ^ tbl_rd_ff;
                  pos_in        = 48'(pos_ff + 48'd1);
               end
            end
            MODE_SEEK: pos_in = req_seek_position;
            default: ;
         endcase
      end

      if (cmd.fill || cmd.tb_wr) idx_in = 8'(idx_ff + 8'd1);
      if (cmd.ks_j) begin
         j_in  = 8'(j_ff + perm_rd_ff + key_rd_ff);
         si_in = perm_rd_ff;
      end
      if (cmd.ks_sw2) begin
         idx_in = 8'(idx_ff + 8'd1);
         if ((KCW'(kidx_ff) + KCW'(1)) == klen_ff) begin
            kidx_in = '0;
         end else begin
            kidx_in = KAW'(kidx_ff + KAW'(1));
         end
      end
      if (cmd.tb_rd_b) si_in = perm_rd_ff;
      if (cmd.emit_ready) begin
         key_ready_in  = 1'b1;
         rsp_load      = 1'b1;
         rsp_data_in   = 8'd0;
         rsp_status_in = STATUS_KEY_READY;
         rsp_last_in   = 1'b1;
      end

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (key_we) key_mem[key_count_ff[KAW-1:0]] <= req_data_byte;
      key_rd_ff <= key_mem[kidx_ff];
   end

   always_ff @(posedge clock) begin
      if (perm_we) perm_mem[perm_waddr] <= perm_wdata;
      perm_rd_ff <= perm_mem[perm_raddr];
   end

   // read side follows the next position so the pad byte is ready at accept
   always_ff @(posedge clock) begin
      if (cmd.tb_wr) tbl_mem[idx_ff] <= perm_rd_ff;
      tbl_rd_ff <= tbl_mem[pos_in[7:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff <= '0;
         key_over_ff  <= 1'b0;
         key_ready_ff <= 1'b0;
         pos_ff       <= '0;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         key_count_ff <= key_count_in;
         key_over_ff  <= key_over_in;
         key_ready_ff <= key_ready_in;
         pos_ff       <= pos_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      klen_ff       <= klen_in;
      kidx_ff       <= kidx_in;
      idx_ff        <= idx_in;
      j_ff          <= j_in;
      si_ff         <= si_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data_out = rsp_data_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_last_out = rsp_last_ff;

`ifndef SYNTHESIS
   a_load_free_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !rsp_valid_ff || !rsp_stall)
      else $error("result register overwritten");
   a_no_ready_mid_key: assert property (@(posedge clock) disable iff (reset)
      key_count_ff != '0 |-> !key_ready_ff)
      else $error("key ready during key load");
   a_pos_on_accept: assert property (@(posedge clock) disable iff (reset)
      !cmd.accept |=> $stable(pos_ff))
      else $error("position moved without an item");
`endif

endmodule

>>> design/rc4_keyed_xor_stream_decoder.sv
// Top level of the RC4 keyed XOR stream decoder.
//
//   channel  prefix  direction  handshake
//   request  req_    in         req_valid / req_stall
//   response rsp_    out        rsp_valid / rsp_stall
//   config   csr_    in         csr_wr_en, no handshake
//
// Audio, seek and non-last key items are taken one per cycle, back to back,
// while req_stall is low. A last key byte that does not overflow the key
// store holds off new items while the box is filled and the key schedule and
// table build run, on one read and one write port of the permutation memory,
// and until key ready is posted. Reset (synchronous) clears key state,
// position, length and result valid; memories are not cleared. req_stall is
// high while the build runs and while the result register is full and stalled.
`timescale 1ns / 1ps

module rc4_keyed_xor_stream_decoder
   import rc4xd_pkg::*;
#(
   parameter int MAX_KEY_BYTES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_in,
   input  logic [47:0] req_seek_position,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_data_out,
   output logic [1:0]  rsp_status,
   output logic        rsp_last_out,
   input  logic        csr_wr_en,
   input  logic [47:0] csr_wr_data
);

   cmd_type cmd;
   sts_type sts;

   rc4xd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   rc4xd_datapath #(
      .MAX_KEY_BYTES (MAX_KEY_BYTES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_mode          (req_mode),
      .req_data_byte     (req_data_byte),
      .req_last_in       (req_last_in),
      .req_seek_position (req_seek_position),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_data_out      (rsp_data_out),
      .rsp_status        (rsp_status),
      .rsp_last_out      (rsp_last_out)
   );

endmodule
